// ===== hw/rtl/wal_record_crc_parser_defines.svh =====
// Assertion macros shared by the log record deframer RTL.
`ifndef WAL_RECORD_CRC_PARSER_DEFINES_SVH
`define WAL_RECORD_CRC_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while arst_n is low.
`define WRCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define WRCP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WRCP_ASSERT(lbl, prop, msg)
`define WRCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/wrcp_pkg.sv =====
// Types, codes and the CRC-32 table for the log record deframer.
package wrcp_pkg;

	// Result kinds as seen on result_kind
	typedef enum logic [1:0] {
		KIND_KEY    = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_COMMIT = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	// Register index, taken from paddr[2]
	localparam logic REG_PUT_CODE = 1'b0;
	localparam logic REG_DEL_CODE = 1'b1;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Classified input beat, front to back
	typedef struct packed {
		logic [7:0] data;
		logic       eol;
		logic       is_put;
		logic       is_del;
	} cls_beat_t;

	// Result beat, back to output queue
	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       kind;
		logic        is_delete;
		logic [31:0] records;
	} res_beat_t;

	typedef logic [31:0] crc_tab_t [256];

	// Reflected CRC-32 byte table, built at elaboration
	function automatic crc_tab_t gen_crc_table();
		crc_tab_t    tab;
		logic [31:0] v;
		for (int i = 0; i < 256; i++) begin
			v = 32'(i);
			for (int j = 0; j < 8; j++) begin
				v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
			end
			tab[i] = v;
		end
		return tab;
	endfunction

	localparam crc_tab_t CRC_TABLE = gen_crc_table();

endpackage

// ===== hw/rtl/wrcp_fifo.sv =====
// Small synchronous FIFO built from registers.
`include "wal_record_crc_parser_defines.svh"
module wrcp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`WRCP_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "fifo count beyond depth")
	`WRCP_ASSERT(a_no_overflow, wr_en |-> (!full || rd_en), "fifo written while full")
	`WRCP_ASSERT(a_no_underflow, rd_en |-> !empty, "fifo read while empty")
	`WRCP_ASSERT(a_cnt_up, (wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + 1'b1, "fifo count slip")

endmodule

// ===== hw/rtl/wrcp_front.sv =====
// Front end: takes log bytes, classifies the type byte, queues the beats.
module wrcp_front #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          log_byte,
	input  logic                end_of_log,
	input  logic [7:0]          put_code,
	input  logic [7:0]          del_code,
	input  logic                mid_rd,
	output wrcp_pkg::cls_beat_t mid_beat,
	output logic                mid_empty
);

	wrcp_pkg::cls_beat_t cls;
	logic                accept;
	logic [$bits(wrcp_pkg::cls_beat_t)-1:0] rd_raw;

	// match flags are only used by the back end in the type phase
	always_comb begin
		cls.data   = log_byte;
		cls.eol    = end_of_log;
		cls.is_del = (log_byte == del_code);
		cls.is_put = (log_byte == put_code);
	end

	assign accept   = push && !full;
	assign mid_beat = wrcp_pkg::cls_beat_t'(rd_raw);

	wrcp_fifo #(
		.WIDTH ($bits(wrcp_pkg::cls_beat_t)),
		.DEPTH (DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (cls),
		.rd_en   (mid_rd),
		.rd_data (rd_raw),
		.full    (full),
		.empty   (mid_empty)
	);

endmodule

// ===== hw/rtl/wrcp_back.sv =====
// Back end: record parser, CRC-32 update and result generation.
`include "wal_record_crc_parser_defines.svh"
module wrcp_back #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wrcp_pkg::cls_beat_t mid_beat,
	input  logic                mid_empty,
	output logic                mid_rd,
	input  logic                out_full,
	output logic                res_wr,
	output wrcp_pkg::res_beat_t res_beat
);

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_KEYLEN,
		PH_KEY,
		PH_VALLEN,
		PH_VAL,
		PH_CRC,
		PH_STOP
	} phase_t;

	// bits of a length field that fit the counter
	localparam logic [31:0] LEN_MASK = 32'((33'd1 << LENGTH_BITS) - 33'd1);

	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] bytes_q, bytes_d;
	logic [1:0]             shift_q, shift_d;
	logic [31:0]            field_q, field_d;
	logic [31:0]            crc_q, crc_d;
	logic                   del_q, del_d;
	logic [31:0]            count_q, count_d;

	logic        go;
	logic [7:0]  b;
	logic [31:0] asm_val;
	logic        last;
	logic [31:0] crc_src;
	logic [31:0] crc_step;
	logic        emit;
	logic [7:0]  emit_byte;
	wrcp_pkg::kind_t emit_kind;

	assign go     = !mid_empty && !out_full;
	assign mid_rd = go;
	assign b      = mid_beat.data;

	assign asm_val  = field_q | ({24'd0, b} << {shift_q, 3'b000});
	assign last     = (shift_q == 2'd3);
	// a new record restarts the CRC at the type byte
	assign crc_src  = (phase_q == PH_TYPE) ? wrcp_pkg::CRC_INIT : crc_q;
	assign crc_step = {8'd0, crc_src[31:8]} ^ wrcp_pkg::CRC_TABLE[crc_src[7:0] ^ b];

	always_comb begin
		phase_d   = phase_q;
		bytes_d   = bytes_q;
		shift_d   = shift_q;
		field_d   = field_q;
		crc_d     = crc_q;
		del_d     = del_q;
		count_d   = count_q;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_kind = wrcp_pkg::KIND_STOP;
		if (mid_beat.eol) begin
			// clean end between records, else a truncated record
			if (phase_q != PH_TYPE && phase_q != PH_STOP) begin
				phase_d = PH_STOP;
				emit    = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_TYPE: begin
					if (mid_beat.is_del || mid_beat.is_put) begin
						del_d   = mid_beat.is_del;
						crc_d   = crc_step;
						shift_d = 2'd0;
						field_d = '0;
						phase_d = PH_KEYLEN;
					end else begin
						del_d   = 1'b0;
						phase_d = PH_STOP;
						emit    = 1'b1;
					end
				end
				PH_KEYLEN, PH_VALLEN: begin
					crc_d = crc_step;
					if (!last) begin
						field_d = asm_val;
						shift_d = shift_q + 2'd1;
					end else if ((asm_val & ~LEN_MASK) != '0) begin
						phase_d = PH_STOP;
						emit    = 1'b1;
					end else begin
						bytes_d = asm_val[LENGTH_BITS-1:0];
						shift_d = 2'd0;
						field_d = '0;
						if (phase_q == PH_KEYLEN) begin
							phase_d = (asm_val == '0) ? PH_VALLEN : PH_KEY;
						end else begin
							phase_d = (asm_val == '0) ? PH_CRC : PH_VAL;
						end
					end
				end
				PH_KEY, PH_VAL: begin
					crc_d     = crc_step;
					bytes_d   = bytes_q - 1'b1;
					emit      = 1'b1;
					emit_byte = b;
					emit_kind = (phase_q == PH_KEY) ? wrcp_pkg::KIND_KEY
						: wrcp_pkg::KIND_VALUE;
					if (bytes_q == LENGTH_BITS'(1)) begin
						shift_d = 2'd0;
						field_d = '0;
						phase_d = (phase_q == PH_KEY) ? PH_VALLEN : PH_CRC;
					end
				end
				PH_CRC: begin
					if (!last) begin
						field_d = asm_val;
						shift_d = shift_q + 2'd1;
					end else if (asm_val != ~crc_q) begin
						phase_d = PH_STOP;
						emit    = 1'b1;
					end else begin
						count_d   = count_q + 32'd1;
						shift_d   = 2'd0;
						field_d   = '0;
						phase_d   = PH_TYPE;
						emit      = 1'b1;
						emit_kind = wrcp_pkg::KIND_COMMIT;
					end
				end
				default: begin
					// stopped: beats are drained and dropped
				end
			endcase
		end
	end

	assign res_wr = go && emit;

	always_comb begin
		res_beat.out_byte  = emit_byte;
		res_beat.kind      = emit_kind;
		res_beat.is_delete = del_d;
		res_beat.records   = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			bytes_q <= '0;
			shift_q <= 2'd0;
			field_q <= '0;
			crc_q   <= wrcp_pkg::CRC_INIT;
			del_q   <= 1'b0;
			count_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			bytes_q <= bytes_d;
			shift_q <= shift_d;
			field_q <= field_d;
			crc_q   <= crc_d;
			del_q   <= del_d;
			count_q <= count_d;
		end
	end

	`WRCP_ASSERT(a_stop_sticky, phase_q == PH_STOP |=> phase_q == PH_STOP, "parser left stop")
	`WRCP_ASSERT(a_res_room, res_wr |-> !out_full, "result written with no room")
	`WRCP_ASSERT(a_commit_cnt, (res_wr && emit_kind == wrcp_pkg::KIND_COMMIT) |=> count_q == $past(count_q) + 32'd1, "commit did not count")

endmodule

// ===== hw/rtl/wal_record_crc_parser.sv =====
// Top level of the write-ahead-log record deframer with CRC-32 check.
//
//  channel   | direction | handshake                 | beat
//  ----------+-----------+---------------------------+--------------------------------------
//  log in    | in        | push / full               | log_byte, end_of_log
//  results   | out       | pop / empty               | out_byte, result_kind, is_delete,
//            |           |                           | records_recovered
//  config    | in        | psel / penable / pready   | paddr, pwdata, prdata (type codes)
//
// One log beat per cycle sustained while the result queue has room: the parser takes one beat a cycle from the
// front queue, doing at most one table CRC byte step and one phase update per beat.
// An accepted input beat is registered in the front queue; any result it gives is then written to the
// result queue, from which it can be popped.
// full rises only when the front queue (MID_DEPTH beats) is filled, which
// happens once the result queue (OUT_DEPTH beats) is full and pop stays low.
// Reset is asynchronous and immediate; no clearing pass follows.
module wal_record_crc_parser #(
	parameter int LENGTH_BITS = 32,
	parameter int MID_DEPTH   = 4,
	parameter int OUT_DEPTH   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// log byte stream
	input  logic        push,
	output logic        full,
	input  logic [7:0]  log_byte,
	input  logic        end_of_log,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [1:0]  result_kind,
	output logic        is_delete,
	output logic [31:0] records_recovered
);

	// type code registers; to be only written while the block is idle, which the block does not enforce
	logic [7:0] put_code_q;
	logic [7:0] del_code_q;
	logic       cfg_wr;

	wrcp_pkg::cls_beat_t mid_beat;
	logic                mid_empty;
	logic                mid_rd;
	logic                res_wr;
	logic                out_full;
	wrcp_pkg::res_beat_t res_beat;
	wrcp_pkg::res_beat_t out_beat;
	logic [$bits(wrcp_pkg::res_beat_t)-1:0] out_raw;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register index is paddr[2]; the low address bits are not decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_code_q <= 8'd1;
			del_code_q <= 8'd2;
		end else if (cfg_wr) begin
			case (paddr[2])
				wrcp_pkg::REG_PUT_CODE: put_code_q <= pwdata[7:0];
				wrcp_pkg::REG_DEL_CODE: del_code_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			wrcp_pkg::REG_PUT_CODE: prdata = {24'd0, put_code_q};
			wrcp_pkg::REG_DEL_CODE: prdata = {24'd0, del_code_q};
			default:                prdata = 32'd0;
		endcase
	end

	// front: accept and classify, queue towards the parser
	wrcp_front #(
		.DEPTH (MID_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.log_byte   (log_byte),
		.end_of_log (end_of_log),
		.put_code   (put_code_q),
		.del_code   (del_code_q),
		.mid_rd     (mid_rd),
		.mid_beat   (mid_beat),
		.mid_empty  (mid_empty)
	);

	// back: parse, check CRC, produce at most one result per beat
	wrcp_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_beat  (mid_beat),
		.mid_empty (mid_empty),
		.mid_rd    (mid_rd),
		.out_full  (out_full),
		.res_wr    (res_wr),
		.res_beat  (res_beat)
	);

	// result queue; head is shown while empty is low
	wrcp_fifo #(
		.WIDTH ($bits(wrcp_pkg::res_beat_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_beat),
		.rd_en   (pop && !empty),
		.rd_data (out_raw),
		.full    (out_full),
		.empty   (empty)
	);

	assign out_beat          = wrcp_pkg::res_beat_t'(out_raw);
	assign out_byte          = out_beat.out_byte;
	assign result_kind       = out_beat.kind;
	assign is_delete         = out_beat.is_delete;
	assign records_recovered = out_beat.records;

endmodule
